// ----- rtl/base64_lenient_decoder_assert.svh -----
// Assertion macros shared by the decoder RTL.
`ifndef BASE64_LENIENT_DECODER_ASSERT_SVH
`define BASE64_LENIENT_DECODER_ASSERT_SVH

// Same-cycle implication checked on every rising clock edge outside reset.
`define B64LD_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Condition checked in the cycle after the trigger.
`define B64LD_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- rtl/b64ld_pkg.sv -----
// Types shared by the base64 decoder modules.
package b64ld_pkg;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] data_byte;
		logic       last;
		logic       error;
	} b64ld_res_t;

	// Up to three results produced by one character, written to the queue together.
	typedef struct packed {
		logic [1:0] num;
		b64ld_res_t r0;
		b64ld_res_t r1;
		b64ld_res_t r2;
	} b64ld_push_t;

endpackage

// ----- rtl/b64ld_step.sv -----
// Per-character decode: alphabet lookup, sextet group state and flush results.
module b64ld_step (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  char_present,
	input  logic [7:0]            text_char,
	input  logic                  end_of_text,
	output b64ld_pkg::b64ld_push_t push
);
	import b64ld_pkg::*;

	localparam logic [7:0] LOWER_OFS = 8'd26;
	localparam logic [7:0] DIGIT_OFS = 8'd52;
	localparam logic [5:0] PLUS_VAL  = 6'd62;
	localparam logic [5:0] SLASH_VAL = 6'd63;
	localparam logic [7:0] CH_PAD    = 8'h3D;

	// {hit, sextet}
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd0;
		if (c >= "A" && c <= "Z") begin
			t = c - "A";
			return {1'b1, t[5:0]};
		end
		if (c >= "a" && c <= "z") begin
			t = c - "a" + LOWER_OFS;
			return {1'b1, t[5:0]};
		end
		if (c >= "0" && c <= "9") begin
			t = c - "0" + DIGIT_OFS;
			return {1'b1, t[5:0]};
		end
		if (c == "+") return {1'b1, PLUS_VAL};
		if (c == "/") return {1'b1, SLASH_VAL};
		return 7'd0;
	endfunction

	logic [17:0] acc_q, acc_n, acc_d;
	logic [1:0]  cnt_q, cnt_n, cnt_d;
	logic        pad_q, pad_n, pad_d;

	always_comb begin
		logic [6:0]  sx;
		logic        hit;
		logic        grp;
		logic [23:0] full;
		sx   = sextet_of(text_char);
		hit  = char_present && !pad_q && sx[6];
		grp  = hit && (cnt_q == 2'd3);
		full = {acc_q, sx[5:0]};

		pad_n = pad_q | (char_present && !pad_q && !sx[6] && (text_char == CH_PAD));
		if (grp) begin
			acc_n = '0;
			cnt_n = 2'd0;
		end else if (hit) begin
			acc_n = {acc_q[11:0], sx[5:0]};
			cnt_n = cnt_q + 2'd1;
		end else begin
			acc_n = acc_q;
			cnt_n = cnt_q;
		end

		push = '0;
		if (grp) begin
			push.num = 2'd3;
			push.r0  = '{byte_valid: 1'b1, data_byte: full[23:16], last: 1'b0, error: 1'b0};
			push.r1  = '{byte_valid: 1'b1, data_byte: full[15:8],  last: 1'b0, error: 1'b0};
			push.r2  = '{byte_valid: 1'b1, data_byte: full[7:0],   last: 1'b0, error: 1'b0};
		end
		if (end_of_text) begin
			case (cnt_n)
				2'd2: begin
					push.num = 2'd1;
					push.r0  = '{byte_valid: 1'b1, data_byte: acc_n[11:4], last: 1'b1,
						error: 1'b0};
				end
				2'd3: begin
					push.num = 2'd2;
					push.r0  = '{byte_valid: 1'b1, data_byte: acc_n[17:10], last: 1'b0,
						error: 1'b0};
					push.r1  = '{byte_valid: 1'b1, data_byte: acc_n[9:2], last: 1'b1,
						error: 1'b0};
				end
				2'd1: begin
					// lone sextet: decode failed
					push.num = 2'd1;
					push.r0  = '{byte_valid: 1'b0, data_byte: 8'd0, last: 1'b1, error: 1'b1};
				end
				default: begin
					if (grp) begin
						push.r2.last = 1'b1;
					end else begin
						push.num = 2'd1;
						push.r0  = '{byte_valid: 1'b0, data_byte: 8'd0, last: 1'b1,
							error: 1'b0};
					end
				end
			endcase
			acc_d = '0;
			cnt_d = 2'd0;
			pad_d = 1'b0;
		end else begin
			acc_d = acc_n;
			cnt_d = cnt_n;
			pad_d = pad_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= 2'd0;
			pad_q <= 1'b0;
		end else if (en) begin
			acc_q <= acc_d;
			cnt_q <= cnt_d;
			pad_q <= pad_d;
		end
	end

endmodule

// ----- rtl/b64ld_outq.sv -----
// Result queue: takes up to three results per cycle, hands out one per cycle while rd_ready is high.
module b64ld_outq #(
	parameter int DEPTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  b64ld_pkg::b64ld_push_t wr,
	output logic                  space,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output logic                  rd_valid,
	input  logic                  rd_ready,
	output b64ld_pkg::b64ld_res_t rd
);
	import b64ld_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p, input logic [1:0] k);
		logic [PW:0] s;
		s = {1'b0, p} + (PW+1)'(k);
		if (s >= (PW+1)'(DEPTH)) s = s - (PW+1)'(DEPTH);
		return s[PW-1:0];
	endfunction

	b64ld_res_t      mem [DEPTH];
	b64ld_res_t      ent [3];
	logic [PW-1:0]   head_q, tail_q;
	logic [CW-1:0]   count_q;
	logic [1:0]      wr_num;
	logic            pop;

	assign ent[0]   = wr.r0;
	assign ent[1]   = wr.r1;
	assign ent[2]   = wr.r2;
	assign wr_num   = wr_en ? wr.num : 2'd0;
	assign rd_valid = (count_q != '0);
	assign pop      = rd_valid && rd_ready;
	assign rd       = mem[head_q];
	assign count    = count_q;
	assign space    = (count_q <= CW'(DEPTH - 3));

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (2'(k) < wr_num) mem[wrap_add(tail_q, 2'(k))] <= ent[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= wrap_add(tail_q, wr_num);
			if (pop) head_q <= wrap_add(head_q, 2'd1);
			count_q <= count_q + CW'(wr_num) - CW'(pop);
		end
	end

endmodule

// ----- rtl/base64_lenient_decoder.sv -----
// Top level of the lenient base64 decoder: input register, decode step, result queue.
// Takes one text character per cycle and returns decoded bytes one per cycle while out_ready
// is high. A character is registered, decoded combinationally against the sextet group
// state, and its zero to three results are written together into a QUEUE_DEPTH-entry result
// queue, from which bytes are read; the input register moves on only while the queue has
// room for three more results, so, as four characters give three bytes, the decoder
// sustains one character per cycle when the consumer takes a byte each cycle.
// Every message ends in exactly one result with last set; error on it means a lone
// leftover sextet and the bytes of that message must be dropped.
module base64_lenient_decoder #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       char_present,
	input  logic [7:0] text_char,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       byte_valid,
	output logic [7:0] data_byte,
	output logic       last,
	output logic       error
);
	import b64ld_pkg::*;
	`include "base64_lenient_decoder_assert.svh"

	localparam int CW = $clog2(QUEUE_DEPTH+1);

	logic        valid_s1;
	logic        present_s1;
	logic [7:0]  char_s1;
	logic        eot_s1;
	logic        advance;
	logic        q_space;
	logic [CW-1:0] q_count;
	b64ld_push_t push;
	b64ld_res_t  head;

	assign advance  = valid_s1 && q_space;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			present_s1 <= char_present;
			char_s1    <= text_char;
			eot_s1     <= end_of_text;
		end
	end

	b64ld_step u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (advance),
		.char_present (present_s1),
		.text_char    (char_s1),
		.end_of_text  (eot_s1),
		.push         (push)
	);

	b64ld_outq #(.DEPTH(QUEUE_DEPTH)) u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (advance),
		.wr       (push),
		.space    (q_space),
		.count    (q_count),
		.rd_valid (out_valid),
		.rd_ready (out_ready),
		.rd       (head)
	);

	assign byte_valid = head.byte_valid;
	assign data_byte  = head.data_byte;
	assign last       = head.last;
	assign error      = head.error;

	`B64LD_ASSERT_IMP(a_count_bound, 1'b1, q_count <= CW'(QUEUE_DEPTH), "result queue overflow")
	`B64LD_ASSERT_NEXT(a_count_track, 1'b1, q_count == $past(q_count) + CW'($past(advance) ? $past(push.num) : 2'd0) - CW'($past(out_valid && out_ready)), "result queue count mismatch")
	`B64LD_ASSERT_IMP(a_err_marker, out_valid && error, last && !byte_valid, "error result is not an end marker")
	`B64LD_ASSERT_IMP(a_eot_result, advance && eot_s1, push.num != 2'd0, "end of text without final result")

endmodule
